// ===== sv/apbt_pkg.sv =====
// Package: shared types, codes and widths of the affine point/box transform.
`timescale 1ns / 1ps

package apbt_pkg;

   localparam int COORD_W   = 32;
   localparam int OPND_W    = 33;
   localparam int PROD_W    = 65;
   localparam int SUM_W     = 68;
   localparam int DET_W     = 65;
   localparam int DMAG_W    = 64;
   localparam int DIV_QBITS = 33;
   localparam int DIV_LAT   = DIV_QBITS + 2;
   // edges from acceptance to the edge that takes the result
   localparam int ITEM_LAT  = DIV_LAT + 5;

   localparam logic [COORD_W-1:0] COORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN  = 32'h8000_0000;
   localparam logic [COORD_W-1:0] COEF_UNITY = 32'h0001_0000;

   typedef enum logic [2:0] {
      CMD_PT_FWD = 3'd0,
      CMD_PT_INV = 3'd1,
      CMD_DT_FWD = 3'd2,
      CMD_DT_INV = 3'd3,
      CMD_BX_FWD = 3'd4,
      CMD_BX_INV = 3'd5
   } apbt_cmd_type;

   typedef enum logic [2:0] {
      REG_COEF_XX = 3'd0,
      REG_COEF_XY = 3'd1,
      REG_COEF_YX = 3'd2,
      REG_COEF_YY = 3'd3,
      REG_SHIFT_X = 3'd4,
      REG_SHIFT_Y = 3'd5
   } apbt_reg_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_SINGULAR  = 2'd1,
      ST_SATURATED = 2'd2
   } apbt_status_type;

   typedef struct packed {
      logic [2:0]                cmd;
      logic signed [COORD_W-1:0] in_x0;
      logic signed [COORD_W-1:0] in_y0;
      logic signed [COORD_W-1:0] in_x1;
      logic signed [COORD_W-1:0] in_y1;
   } apbt_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x0;
      logic signed [COORD_W-1:0] out_y0;
      logic signed [COORD_W-1:0] out_x1;
      logic signed [COORD_W-1:0] out_y1;
      apbt_status_type           status;
   } apbt_rsp_type;

   typedef struct packed {
      logic valid;
      logic inverse;
      logic shift;
      logic box;
      logic singular;
      logic blank;
   } apbt_ctrl_type;

   typedef struct packed {
      apbt_ctrl_type            ctrl;
      logic signed [OPND_W-1:0] x0;
      logic signed [OPND_W-1:0] x1;
      logic signed [OPND_W-1:0] y0;
      logic signed [OPND_W-1:0] y1;
   } apbt_word_type;

   typedef struct packed {
      logic [DMAG_W-1:0] mag;
      logic              neg;
   } apbt_det_type;

   typedef struct packed {
      logic                      sat;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } apbt_corner_type;

endpackage

// ===== sv/affine_point_bbox_transform.sv =====
// Top level: register file, front end, queue and back end of the transform.
`timescale 1ns / 1ps

// A command is taken on every cycle with start high and busy low; its result
// word strobes on rsp_valid later, in the order taken, whatever the command.
// The latency is set by the inverse path, a 33-step pipelined restoring
// divider that forms the rounded quotient by the determinant; forward
// commands ride alongside it to keep results in order. The receiver cannot
// stall, so the back end never stops. After reset and after each register
// write busy stays high while the determinant is rebuilt.

module affine_point_bbox_transform import apbt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  apbt_req_type       req_data,
   output logic               rsp_valid,
   output apbt_rsp_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [COORD_W-1:0] csr_wdata
);

   logic signed [COORD_W-1:0] coef_xx_ff, coef_xy_ff, coef_yx_ff, coef_yy_ff;
   logic signed [COORD_W-1:0] shift_x_ff, shift_y_ff;
   logic                      cfg_write;
   logic                      q_full, q_push, q_pop, q_valid;
   apbt_word_type             push_word, q_word;
   apbt_det_type              det_info;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff <= COEF_UNITY;
         coef_xy_ff <= '0;
         coef_yx_ff <= '0;
         coef_yy_ff <= COEF_UNITY;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (cfg_write) begin
         case (csr_index)
            REG_COEF_XX: coef_xx_ff <= csr_wdata;
            REG_COEF_XY: coef_xy_ff <= csr_wdata;
            REG_COEF_YX: coef_yx_ff <= csr_wdata;
            REG_COEF_YY: coef_yy_ff <= csr_wdata;
            REG_SHIFT_X: shift_x_ff <= csr_wdata;
            REG_SHIFT_Y: shift_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   apbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg_write (cfg_write),
      .coef_xx   (coef_xx_ff),
      .coef_xy   (coef_xy_ff),
      .coef_yx   (coef_yx_ff),
      .coef_yy   (coef_yy_ff),
      .shift_x   (shift_x_ff),
      .shift_y   (shift_y_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_word    (push_word),
      .det_info  (det_info)
   );

   apbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .word      (q_word)
   );

   apbt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .coef_xx   (coef_xx_ff),
      .coef_xy   (coef_xy_ff),
      .coef_yx   (coef_yx_ff),
      .coef_yy   (coef_yy_ff),
      .shift_x   (shift_x_ff),
      .shift_y   (shift_y_ff),
      .det_info  (det_info),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##ITEM_LAT rsp_valid)
      else $error("accepted word gave no result at the expected cycle");

   a_latency_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ITEM_LAT))
      else $error("result without a matching accepted word");

   a_cfg_busy : assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("not busy while the determinant settles");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_SINGULAR) |->
         (rsp_data.out_x0 == '0 && rsp_data.out_y0 == '0 &&
          rsp_data.out_x1 == '0 && rsp_data.out_y1 == '0))
      else $error("singular result carries non-zero coordinates");

endmodule

// ===== sv/apbt_queue.sv =====
// Two-word queue between the classifying front and the arithmetic back.
`timescale 1ns / 1ps

module apbt_queue import apbt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  apbt_word_type push_word,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output apbt_word_type word
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   apbt_word_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign valid = (cnt_ff != '0);
   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign word  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule

// ===== sv/apbt_front.sv =====
// Front end: takes commands, decodes them, tracks the determinant.
`timescale 1ns / 1ps

module apbt_front import apbt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  apbt_req_type              req_data,
   input  logic                      cfg_write,
   input  logic signed [COORD_W-1:0] coef_xx,
   input  logic signed [COORD_W-1:0] coef_xy,
   input  logic signed [COORD_W-1:0] coef_yx,
   input  logic signed [COORD_W-1:0] coef_yy,
   input  logic signed [COORD_W-1:0] shift_x,
   input  logic signed [COORD_W-1:0] shift_y,
   input  logic                      q_full,
   output logic                      q_push,
   output apbt_word_type             q_word,
   output apbt_det_type              det_info
);

   logic signed [2*COORD_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [DET_W-1:0]     det_ff, det_in;
   apbt_det_type                det_info_ff, det_info_in;
   logic [1:0]                  settle_ff, settle_in;
   apbt_ctrl_type               ctl;
   logic signed [OPND_W-1:0]    sub_x, sub_y;

   assign pa_in  = coef_xx * coef_yy;
   assign pb_in  = coef_xy * coef_yx;
   assign det_in = DET_W'(pa_ff) - DET_W'(pb_ff);

   always_comb begin
      det_info_in.neg = det_ff[DET_W-1];
      det_info_in.mag = det_ff[DET_W-1] ? DMAG_W'(-det_ff) : DMAG_W'(det_ff);
   end

   // determinant settles through the product, det and det_info registers after any register write
   assign settle_in = cfg_write ? 2'd3 : ((settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0);
   assign busy      = (settle_ff != 2'd0) || q_full;
   assign q_push    = start && !busy;
   assign det_info  = det_info_ff;

   always_comb begin
      ctl = '0;
      ctl.valid = 1'b1;
      case (req_data.cmd)
         CMD_PT_FWD: begin
            ctl.shift = 1'b1;
         end
         CMD_PT_INV: begin
            ctl.shift   = 1'b1;
            ctl.inverse = 1'b1;
         end
         CMD_DT_FWD: begin
            ctl.shift = 1'b0;
         end
         CMD_DT_INV: begin
            ctl.inverse = 1'b1;
         end
         CMD_BX_FWD: begin
            ctl.shift = 1'b1;
            ctl.box   = 1'b1;
         end
         CMD_BX_INV: begin
            ctl.shift   = 1'b1;
            ctl.box     = 1'b1;
            ctl.inverse = 1'b1;
         end
         default: begin
            ctl.blank = 1'b1;
         end
      endcase
      ctl.singular = ctl.inverse && (det_ff == '0);
   end

   assign sub_x = (ctl.inverse && ctl.shift) ? OPND_W'(shift_x) : '0;
   assign sub_y = (ctl.inverse && ctl.shift) ? OPND_W'(shift_y) : '0;

   always_comb begin
      q_word.ctrl = ctl;
      q_word.x0   = OPND_W'(req_data.in_x0) - sub_x;
      q_word.x1   = OPND_W'(req_data.in_x1) - sub_x;
      q_word.y0   = OPND_W'(req_data.in_y0) - sub_y;
      q_word.y1   = OPND_W'(req_data.in_y1) - sub_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd3;
      end else begin
         settle_ff <= settle_in;
      end
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      det_ff      <= det_in;
      det_info_ff <= det_info_in;
   end

endmodule

// ===== sv/apbt_div.sv =====
// Pipelined restoring divider lane: rounded quotient of num by the determinant.
`timescale 1ns / 1ps

module apbt_div import apbt_pkg::*; #(
   parameter int NW = 84
) (
   input  logic                    clock,
   input  logic signed [NW-1:0]    num,
   input  logic [DMAG_W-1:0]       dmag,
   input  logic                    dneg,
   output logic [DIV_QBITS-1:0]    quo,
   output logic                    ovf,
   output logic                    neg
);

   localparam int AW = NW + 2;
   localparam int BW = DMAG_W + 1;
   localparam int RW = ((AW > BW + DIV_QBITS) ? AW : BW + DIV_QBITS) + 1;
   localparam int NS = DIV_QBITS + 2;

   logic [RW-1:0]        rem_ff [NS];
   logic [DIV_QBITS-1:0] quo_ff [NS];
   logic                 ovf_ff [NS];
   logic                 neg_ff [NS];
   logic [NW-1:0]        nmag;
   logic [RW-1:0]        bext;

   // the user must keep the determinant steady while items are in flight; the block itself does not enforce it
   assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
   assign bext = RW'({dmag, 1'b0});

   // round to nearest: (2|n| + |d|) / (2|d|)
   always_ff @(posedge clock) begin
      rem_ff[0] <= RW'({nmag, 1'b0}) + RW'(dmag);
      quo_ff[0] <= '0;
      ovf_ff[0] <= 1'b0;
      neg_ff[0] <= num[NW-1] ^ dneg;
      rem_ff[1] <= rem_ff[0];
      quo_ff[1] <= '0;
      ovf_ff[1] <= (rem_ff[0] >= (bext << DIV_QBITS));
      neg_ff[1] <= neg_ff[0];
   end

   for (genvar s = 2; s < NS; s++) begin : g_step
      localparam int J = NS - 1 - s;
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = bext << J;
      assign ge  = (rem_ff[s-1] >= dsh);
      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? rem_ff[s-1] - dsh : rem_ff[s-1];
         quo_ff[s] <= quo_ff[s-1] | (ge ? (DIV_QBITS'(1) << J) : '0);
         ovf_ff[s] <= ovf_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
      end
   end

   assign quo = quo_ff[NS-1];
   assign ovf = ovf_ff[NS-1];
   assign neg = neg_ff[NS-1];

endmodule

// ===== sv/apbt_back.sv =====
// Back end: products, sums, divider lanes, saturation and box reduction.
`timescale 1ns / 1ps

module apbt_back import apbt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  apbt_word_type             q_word,
   output logic                      q_pop,
   input  logic signed [COORD_W-1:0] coef_xx,
   input  logic signed [COORD_W-1:0] coef_xy,
   input  logic signed [COORD_W-1:0] coef_yx,
   input  logic signed [COORD_W-1:0] coef_yy,
   input  logic signed [COORD_W-1:0] shift_x,
   input  logic signed [COORD_W-1:0] shift_y,
   input  apbt_det_type              det_info,
   output logic                      rsp_valid,
   output apbt_rsp_type              rsp_data
);

   localparam int NUM_W  = SUM_W + FRAC_BITS;
   localparam int HALF_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
   localparam logic signed [SUM_W-1:0] HALF = (FRAC_BITS > 0) ? (SUM_W'(1) << HALF_SH) : '0;

   function automatic logic [COORD_W:0] fwd_fix(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] t;
      logic [SUM_W-COORD_W:0]  hi;
      t  = s >>> FRAC_BITS;
      hi = t[SUM_W-1:COORD_W-1];
      if ((hi == '0) || (hi == '1)) begin
         return {1'b0, t[COORD_W-1:0]};
      end else if (t[SUM_W-1]) begin
         return {1'b1, COORD_MIN};
      end else begin
         return {1'b1, COORD_MAX};
      end
   endfunction

   function automatic logic [COORD_W:0] inv_fix(input logic [DIV_QBITS-1:0] q,
                                                input logic ov, input logic ng);
      logic [DIV_QBITS-1:0] t;
      t = ng ? (DIV_QBITS'(0) - q) : q;
      if (ov) begin
         return {1'b1, ng ? COORD_MIN : COORD_MAX};
      end else if (!ng && (q > DIV_QBITS'(COORD_MAX))) begin
         return {1'b1, COORD_MAX};
      end else if (ng && (q > DIV_QBITS'(COORD_MIN))) begin
         return {1'b1, COORD_MIN};
      end else begin
         return {1'b0, t[COORD_W-1:0]};
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
      return (b < a) ? b : a;
   endfunction

   function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
      return (b > a) ? b : a;
   endfunction

   // product stage
   apbt_ctrl_type            ctl_p_ff, ctl_p_in;
   logic signed [OPND_W-1:0] xo [2];
   logic signed [OPND_W-1:0] yo [2];
   logic signed [COORD_W-1:0] coef_a, coef_b;
   logic signed [PROD_W-1:0] pxa_ff [2], pxb_ff [2], pya_ff [2], pyb_ff [2];
   logic signed [SUM_W-1:0]  offx_ff, offx_in, offy_ff, offy_in;

   assign q_pop = q_valid;
   assign xo[0] = q_word.x0;
   assign xo[1] = q_word.x1;
   assign yo[0] = q_word.y0;
   assign yo[1] = q_word.y1;
   assign coef_a = q_word.ctrl.inverse ? coef_yy : coef_xx;
   assign coef_b = q_word.ctrl.inverse ? coef_xx : coef_yy;

   always_comb begin
      ctl_p_in       = q_word.ctrl;
      ctl_p_in.valid = q_valid;
      offx_in = HALF;
      offy_in = HALF;
      if (q_word.ctrl.shift && !q_word.ctrl.inverse) begin
         offx_in = (SUM_W'(shift_x) <<< FRAC_BITS) + HALF;
         offy_in = (SUM_W'(shift_y) <<< FRAC_BITS) + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff.valid <= 1'b0;
      end else begin
         ctl_p_ff <= ctl_p_in;
      end
      for (int i = 0; i < 2; i++) begin
         pxa_ff[i] <= PROD_W'(coef_a) * PROD_W'(xo[i]);
         pxb_ff[i] <= PROD_W'(coef_yx) * PROD_W'(xo[i]);
         pya_ff[i] <= PROD_W'(coef_xy) * PROD_W'(yo[i]);
         pyb_ff[i] <= PROD_W'(coef_b) * PROD_W'(yo[i]);
      end
      offx_ff <= offx_in;
      offy_ff <= offy_in;
   end

   // sum stage, corners (x0,y0) (x1,y1) (x0,y1) (x1,y0)
   apbt_ctrl_type           ctl_s_ff;
   logic signed [SUM_W-1:0] sum_x_ff [4], sum_y_ff [4];

   for (genvar k = 0; k < 4; k++) begin : g_sum
      localparam int XI = k % 2;
      localparam int YJ = (k == 1 || k == 2) ? 1 : 0;
      always_ff @(posedge clock) begin
         if (ctl_p_ff.inverse) begin
            sum_x_ff[k] <= SUM_W'(pxa_ff[XI]) - SUM_W'(pya_ff[YJ]);
            sum_y_ff[k] <= SUM_W'(pyb_ff[YJ]) - SUM_W'(pxb_ff[XI]);
         end else begin
            sum_x_ff[k] <= SUM_W'(pxa_ff[XI]) + SUM_W'(pya_ff[YJ]) + offx_ff;
            sum_y_ff[k] <= SUM_W'(pxb_ff[XI]) + SUM_W'(pyb_ff[YJ]) + offy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s_ff.valid <= 1'b0;
      end else begin
         ctl_s_ff <= ctl_p_ff;
      end
   end

   // divider lanes with the forward results riding alongside
   logic signed [NUM_W-1:0] num_x [4], num_y [4];
   logic [DIV_QBITS-1:0]    qx [4], qy [4];
   logic                    ovx [4], ovy [4], ngx [4], ngy [4];
   apbt_corner_type [3:0]   fwd_in;
   apbt_corner_type [3:0]   fwd_ff [DIV_LAT];
   apbt_ctrl_type           ctl_d_ff [DIV_LAT];

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [COORD_W:0] fx, fy;
      assign num_x[k] = NUM_W'(sum_x_ff[k]) <<< FRAC_BITS;
      assign num_y[k] = NUM_W'(sum_y_ff[k]) <<< FRAC_BITS;
      assign fx = fwd_fix(sum_x_ff[k]);
      assign fy = fwd_fix(sum_y_ff[k]);
      assign fwd_in[k].sat = fx[COORD_W] | fy[COORD_W];
      assign fwd_in[k].x   = fx[COORD_W-1:0];
      assign fwd_in[k].y   = fy[COORD_W-1:0];

      apbt_div #(.NW(NUM_W)) u_div_x (
         .clock (clock),
         .num   (num_x[k]),
         .dmag  (det_info.mag),
         .dneg  (det_info.neg),
         .quo   (qx[k]),
         .ovf   (ovx[k]),
         .neg   (ngx[k])
      );

      apbt_div #(.NW(NUM_W)) u_div_y (
         .clock (clock),
         .num   (num_y[k]),
         .dmag  (det_info.mag),
         .dneg  (det_info.neg),
         .quo   (qy[k]),
         .ovf   (ovy[k]),
         .neg   (ngy[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            ctl_d_ff[i].valid <= 1'b0;
         end
      end else begin
         ctl_d_ff[0] <= ctl_s_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            ctl_d_ff[i] <= ctl_d_ff[i-1];
         end
      end
      fwd_ff[0] <= fwd_in;
      for (int i = 1; i < DIV_LAT; i++) begin
         fwd_ff[i] <= fwd_ff[i-1];
      end
   end

   // select and saturate
   apbt_ctrl_type         ctl_f_ff;
   apbt_corner_type [3:0] cor_ff, cor_in;

   always_comb begin
      logic [COORD_W:0] ix, iy;
      cor_in = fwd_ff[DIV_LAT-1];
      for (int k = 0; k < 4; k++) begin
         ix = inv_fix(qx[k], ovx[k], ngx[k]);
         iy = inv_fix(qy[k], ovy[k], ngy[k]);
         if (ctl_d_ff[DIV_LAT-1].inverse) begin
            cor_in[k].sat = ix[COORD_W] | iy[COORD_W];
            cor_in[k].x   = ix[COORD_W-1:0];
            cor_in[k].y   = iy[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_f_ff.valid <= 1'b0;
      end else begin
         ctl_f_ff <= ctl_d_ff[DIV_LAT-1];
      end
      cor_ff <= cor_in;
   end

   // box reduction and output register
   logic         rsp_valid_ff;
   apbt_rsp_type rsp_data_ff, rsp_data_in;
   logic         any_sat;

   always_comb begin
      rsp_data_in = '0;
      any_sat     = cor_ff[0].sat;
      if (ctl_f_ff.box) begin
         any_sat = cor_ff[0].sat | cor_ff[1].sat | cor_ff[2].sat | cor_ff[3].sat;
         rsp_data_in.out_x0 = smin(smin(cor_ff[0].x, cor_ff[1].x), smin(cor_ff[2].x, cor_ff[3].x));
         rsp_data_in.out_y0 = smin(smin(cor_ff[0].y, cor_ff[1].y), smin(cor_ff[2].y, cor_ff[3].y));
         rsp_data_in.out_x1 = smax(smax(cor_ff[0].x, cor_ff[1].x), smax(cor_ff[2].x, cor_ff[3].x));
         rsp_data_in.out_y1 = smax(smax(cor_ff[0].y, cor_ff[1].y), smax(cor_ff[2].y, cor_ff[3].y));
      end else begin
         rsp_data_in.out_x0 = cor_ff[0].x;
         rsp_data_in.out_y0 = cor_ff[0].y;
      end
      rsp_data_in.status = any_sat ? ST_SATURATED : ST_OK;
      if (ctl_f_ff.singular) begin
         rsp_data_in        = '0;
         rsp_data_in.status = ST_SINGULAR;
      end else if (ctl_f_ff.blank) begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_f_ff.valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/testbench.sv =====
// Testbench for the affine point/box transform: directed and random commands.
`timescale 1ns / 1ps

module testbench;
   import apbt_pkg::*;

   typedef logic signed [127:0] wide_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   apbt_req_type       req_data;
   logic               rsp_valid;
   apbt_rsp_type       rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [COORD_W-1:0] csr_wdata;

   logic signed [COORD_W-1:0] coef_reg [6];
   apbt_rsp_type              expected_words [$];
   int                        error_count;
   int                        words_checked;
   int                        items_sent;

   affine_point_bbox_transform #(.FRAC_BITS(16)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---- transform predictor ----
   function automatic logic signed [31:0] clamp32(wide_type v, inout bit sat);
      if (v > wide_type'(64'sd2147483647)) begin
         sat = 1'b1;
         return COORD_MAX;
      end
      if (v < -wide_type'(64'sd2147483648)) begin
         sat = 1'b1;
         return COORD_MIN;
      end
      return v[31:0];
   endfunction

   function automatic wide_type round_div(wide_type n, wide_type d);
      bit       neg;
      wide_type an;
      wide_type ad;
      wide_type q;
      neg = (n < 0) != (d < 0);
      an  = (n < 0) ? -n : n;
      ad  = (d < 0) ? -d : d;
      q   = (2 * an + ad) / (2 * ad);
      return neg ? -q : q;
   endfunction

   function automatic wide_type determinant();
      wide_type kxx, kxy, kyx, kyy;
      kxx = coef_reg[REG_COEF_XX];
      kxy = coef_reg[REG_COEF_XY];
      kyx = coef_reg[REG_COEF_YX];
      kyy = coef_reg[REG_COEF_YY];
      return kxx * kyy - kxy * kyx;
   endfunction

   function automatic void map_point(bit inverse, wide_type x, wide_type y, bit shift,
                                     inout bit sat,
                                     output logic signed [31:0] ox, output logic signed [31:0] oy);
      wide_type kxx, kxy, kyx, kyy, ksx, ksy, ax, ay, d;
      kxx = coef_reg[REG_COEF_XX];
      kxy = coef_reg[REG_COEF_XY];
      kyx = coef_reg[REG_COEF_YX];
      kyy = coef_reg[REG_COEF_YY];
      ksx = coef_reg[REG_SHIFT_X];
      ksy = coef_reg[REG_SHIFT_Y];
      if (!inverse) begin
         ax = kxx * x + kxy * y;
         ay = kyx * x + kyy * y;
         if (shift) begin
            ax = ax + (ksx <<< 16);
            ay = ay + (ksy <<< 16);
         end
         ax = ax + (wide_type'(1) <<< 15);
         ay = ay + (wide_type'(1) <<< 15);
         ox = clamp32(ax >>> 16, sat);
         oy = clamp32(ay >>> 16, sat);
      end else begin
         d = determinant();
         if (shift) begin
            x = x - ksx;
            y = y - ksy;
         end
         ax = kyy * x - kxy * y;
         ay = kxx * y - kyx * x;
         ox = clamp32(round_div(ax <<< 16, d), sat);
         oy = clamp32(round_div(ay <<< 16, d), sat);
      end
   endfunction

   function automatic apbt_rsp_type predict_transform(apbt_req_type rq);
      apbt_rsp_type r;
      bit sat;
      bit inverse;
      wide_type x0, y0, x1, y1;
      logic signed [31:0] cx [4];
      logic signed [31:0] cy [4];
      r = '0;
      sat = 1'b0;
      inverse = rq.cmd[0];
      x0 = rq.in_x0;
      y0 = rq.in_y0;
      x1 = rq.in_x1;
      y1 = rq.in_y1;
      if (rq.cmd <= 3'd5 && inverse && determinant() == 0) begin
         r.status = ST_SINGULAR;
         return r;
      end
      if (rq.cmd <= 3'd3) begin
         map_point(inverse, x0, y0, rq.cmd < 3'd2, sat, r.out_x0, r.out_y0);
      end else if (rq.cmd <= 3'd5) begin
         map_point(inverse, x0, y0, 1'b1, sat, cx[0], cy[0]);
         map_point(inverse, x1, y1, 1'b1, sat, cx[1], cy[1]);
         map_point(inverse, x0, y1, 1'b1, sat, cx[2], cy[2]);
         map_point(inverse, x1, y0, 1'b1, sat, cx[3], cy[3]);
         r.out_x0 = cx[0];
         r.out_x1 = cx[0];
         r.out_y0 = cy[0];
         r.out_y1 = cy[0];
         for (int k = 1; k < 4; k++) begin
            if (cx[k] < r.out_x0) r.out_x0 = cx[k];
            if (cx[k] > r.out_x1) r.out_x1 = cx[k];
            if (cy[k] < r.out_y0) r.out_y0 = cy[k];
            if (cy[k] > r.out_y1) r.out_y1 = cy[k];
         end
      end
      r.status = sat ? ST_SATURATED : ST_OK;
      return r;
   endfunction

   // ---- driving ----
   task automatic send_item(input apbt_req_type rq);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      expected_words.push_back(predict_transform(rq));
      items_sent++;
   endtask

   task automatic pause_cycles(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      pause_cycles(1);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (ITEM_LAT + 2) @(posedge clock);
   endtask

   task automatic write_reg(input apbt_reg_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      coef_reg[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_matrix(input logic [31:0] xx, xy, yx, yy, sx, sy);
      drain();
      write_reg(REG_COEF_XX, xx);
      write_reg(REG_COEF_XY, xy);
      write_reg(REG_COEF_YX, yx);
      write_reg(REG_COEF_YY, yy);
      write_reg(REG_SHIFT_X, sx);
      write_reg(REG_SHIFT_Y, sy);
   endtask

   function automatic apbt_req_type make_req(logic [2:0] cmd, logic [31:0] x0, y0, x1, y1);
      apbt_req_type rq;
      rq.cmd   = cmd;
      rq.in_x0 = x0;
      rq.in_y0 = y0;
      rq.in_x1 = x1;
      rq.in_y1 = y1;
      return rq;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 3) == 0 ? COORD_MAX : COORD_MIN;
         2: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
         default: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         2: return 32'd0;
         default: return 32'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
      endcase
   endfunction

   // ---- checking ----
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      apbt_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_data.status, 0);
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_data.out_x0 !== want.out_x0)
               report_mismatch("out_x0", rsp_data.out_x0, want.out_x0);
            if (rsp_data.out_y0 !== want.out_y0)
               report_mismatch("out_y0", rsp_data.out_y0, want.out_y0);
            if (rsp_data.out_x1 !== want.out_x1)
               report_mismatch("out_x1", rsp_data.out_x1, want.out_x1);
            if (rsp_data.out_y1 !== want.out_y1)
               report_mismatch("out_y1", rsp_data.out_y1, want.out_y1);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
         end
      end
   end

   // ---- tests ----
   task automatic test_identity_extremes();
      send_item(make_req(CMD_PT_FWD, 32'h0001_8000, 32'h0002_8000, 0, 0));
      send_item(make_req(CMD_PT_INV, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
      send_item(make_req(CMD_DT_FWD, COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 0));
      send_item(make_req(CMD_DT_INV, 32'hFFFF_FFFF, 1, 0, 0));
      send_item(make_req(CMD_BX_FWD, 32'h0005_0000, 32'h0006_0000, 32'hFFFD_0000, 32'h0001_0000));
      send_item(make_req(CMD_BX_INV, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      send_item(make_req(3'd6, 32'h1234_5678, 1, 2, 3));
      send_item(make_req(3'd7, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
   endtask

   task automatic test_rounding_and_saturation();
      // half scale: ties on the forward map and on the divide
      load_matrix(32'h0000_8000, 0, 0, 32'h0002_0000, 32'hFFFF_8000, 32'h0000_0001);
      send_item(make_req(CMD_PT_FWD, 1, 32'hFFFF_FFFF, 0, 0));
      send_item(make_req(CMD_DT_FWD, 32'hFFFF_FFFF, 1, 0, 0));
      send_item(make_req(CMD_DT_INV, 1, 1, 0, 0));
      send_item(make_req(CMD_PT_INV, COORD_MAX, COORD_MIN, 0, 0));
      send_item(make_req(CMD_BX_FWD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_item(make_req(CMD_BX_INV, 32'hFFFF_FFFF, 32'h0000_0003, 1, 32'hFFFF_FFFD));
      load_matrix(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      send_item(make_req(CMD_PT_FWD, COORD_MAX, COORD_MAX, 0, 0));
      send_item(make_req(CMD_PT_INV, COORD_MIN, COORD_MAX, 0, 0));
      send_item(make_req(CMD_BX_INV, 0, 0, 1, 1));
   endtask

   task automatic test_singular();
      load_matrix(0, 32'h0001_0000, 0, 32'h0003_0000, 32'h0000_1000, 32'hFFFF_0000);
      send_item(make_req(CMD_PT_INV, 5, 5, 0, 0));
      send_item(make_req(CMD_DT_INV, COORD_MAX, COORD_MAX, 0, 0));
      send_item(make_req(CMD_BX_INV, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_item(make_req(CMD_PT_FWD, COORD_MAX, COORD_MAX, 0, 0));
      send_item(make_req(CMD_BX_FWD, 1, 2, 3, 4));
   endtask

   task automatic test_random_phases();
      int n;
      int burst;
      logic [31:0] a, b, c;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                           rand_coord(), rand_coord());
            1: begin
               // rank one: xx*yy == xy*yx
               a = $urandom_range(0, 255);
               b = $urandom_range(0, 255);
               c = $urandom_range(0, 255);
               load_matrix(a * b, a * c, b * b, b * c, rand_coord(), rand_coord());
            end
            2: load_matrix($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom());
            default: load_matrix(32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17),
                                 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17),
                                 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17),
                                 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17),
                                 rand_coord(), rand_coord());
         endcase
         n = 0;
         while (n < 244) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < 244; k++) begin
               send_item(make_req($urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
                                                               : 3'($urandom_range(0, 5)),
                                  rand_coord(), rand_coord(), rand_coord(), rand_coord()));
               n++;
            end
            if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(0, 6));
         end
      end
   endtask

   initial begin
      error_count   = 0;
      words_checked = 0;
      items_sent    = 0;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      coef_reg[REG_COEF_XX] = COEF_UNITY;
      coef_reg[REG_COEF_XY] = '0;
      coef_reg[REG_COEF_YX] = '0;
      coef_reg[REG_COEF_YY] = COEF_UNITY;
      coef_reg[REG_SHIFT_X] = '0;
      coef_reg[REG_SHIFT_Y] = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_identity_extremes();
      test_rounding_and_saturation();
      test_singular();
      test_random_phases();
      drain();

      $display("%0d commands sent over identity, scaled, singular, extreme and random matrices;",
               items_sent);
      $display("%0d result words compared, %0d mismatches", words_checked, error_count);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
